### hdl/isotp_pkg.sv
// Shared constants and codes for the ISO-TP frame segmenter.
package isotp_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 88;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_MODE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_ADDR   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_ADDR   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TA_FUNCTIONAL = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FUNCTIONAL_ID = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_SIZE    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_ST_MIN        = 3'd6;

  // Request modes
  localparam logic [2:0] MODE_SINGLE      = 3'd0;
  localparam logic [2:0] MODE_FIRST       = 3'd1;
  localparam logic [2:0] MODE_CONSECUTIVE = 3'd2;
  localparam logic [2:0] MODE_FLOW_CTRL   = 3'd3;
  localparam logic [2:0] MODE_RELEASE     = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_LEN     = 3'd1;
  localparam logic [2:0] ST_BUSY        = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_IDLE        = 3'd4;
  localparam logic [2:0] ST_BAD_FS      = 3'd5;
  localparam logic [2:0] ST_BAD_ID      = 3'd6;

  // Protocol control nibbles
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;
  localparam logic [3:0] PCI_FC = 4'h3;

  localparam logic [1:0]  FS_INVALID    = 2'd3;
  localparam logic [7:0]  PAD_BYTE      = 8'hCC;
  localparam logic [31:0] SF_MAX_NORMAL = 32'd7;
  localparam logic [31:0] SF_MAX_EXT    = 32'd6;
  localparam logic [31:0] FF_SHORT_MAX  = 32'd4095;
  localparam logic [31:0] FF_CARRIED    = 32'd6;
  localparam logic [31:0] CF_MAX        = 32'd7;
  localparam logic [3:0]  FRAME_LEN_OK  = 4'd8;

  localparam int FRAME_BYTES = 8;
  localparam int PAY_BYTES   = 7;

endpackage

### hdl/isotp_frame_segmenter.sv
// ISO-TP frame segmenter: builds classic CAN transport frames from requests.
// Each request passes the input register, then the result register, and is held
// there while the output is stalled. Throughput: one request per cycle while the
// output is not stalled; the session state (busy, sequence number, bytes left)
// is updated in the same cycle a request passes to the result register.
// Reset (rst_n low, synchronous): configuration registers and session state clear,
// both pipeline stages empty.
module isotp_frame_segmenter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // msg_len[31:0], payload_bytes[87:32], flow_status[89:88], zero fill
  input  logic [isotp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode[2:0]
  input  logic [isotp_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // frame_bytes[63:0], frame_len[67:64], can_id[78:68], status[81:79], zero fill
  output logic [isotp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_we,
  input  logic [isotp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [isotp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import isotp_pkg::*;

  // Configuration registers
  logic        addr_mode_r;
  logic [7:0]  target_addr_r;
  logic [7:0]  source_addr_r;
  logic        ta_functional_r;
  logic [10:0] functional_id_r;
  logic [7:0]  block_size_r;
  logic [7:0]  st_min_r;

  // Session state
  logic        busy_r, busy_nxt;
  logic [3:0]  seq_r, seq_nxt;
  logic [31:0] left_r, left_nxt;

  // Input stage
  logic                     s1_valid_r;
  logic [2:0]               s1_mode_r;
  logic [31:0]              s1_len_r;
  logic [PAY_BYTES-1:0][7:0] s1_pay_r;
  logic [1:0]               s1_fs_r;

  // Result stage
  logic        out_valid_r;
  logic [63:0] out_frame_r;
  logic [3:0]  out_len_r;
  logic [10:0] out_id_r;
  logic [2:0]  out_status_r;

  logic out_adv, s1_fire, in_fire;

  logic [10:0] can_id;
  logic        built;
  logic [2:0]  res_status;
  logic [0:FRAME_BYTES-1][7:0] frame;
  logic [0:FRAME_BYTES-1][7:0] sf_norm, sf_ext, ff_short, ff_long, cf_bytes, fc_bytes;
  logic [0:PAY_BYTES-1][7:0]   pay_b;
  logic [2:0]  cf_n;
  logic [31:0] cf_left;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_id_r, out_len_r, out_frame_r};

  // Identifier from the address configuration
  always_comb begin
    if (ta_functional_r) begin
      can_id = functional_id_r;
    end else if (!addr_mode_r) begin
      can_id = {source_addr_r[4:0], target_addr_r[4:0], 1'b0};
    end else begin
      can_id = {source_addr_r, 3'b000};
    end
  end

  assign pay_b   = s1_pay_r;
  assign cf_n    = (left_r < CF_MAX) ? left_r[2:0] : CF_MAX[2:0];
  assign cf_left = left_r - {29'b0, cf_n};

  // Candidate frames for each request kind
  always_comb begin
    sf_norm[0] = s1_len_r[7:0];
    for (int k = 1; k < FRAME_BYTES; k++) begin
      sf_norm[k] = (3'(k - 1) < s1_len_r[2:0]) ? pay_b[k-1] : PAD_BYTE;
    end

    sf_ext[0] = target_addr_r;
    sf_ext[1] = s1_len_r[7:0];
    for (int k = 2; k < FRAME_BYTES; k++) begin
      sf_ext[k] = (3'(k - 2) < s1_len_r[2:0]) ? pay_b[k-2] : PAD_BYTE;
    end

    ff_short[0] = {PCI_FF, s1_len_r[11:8]};
    ff_short[1] = s1_len_r[7:0];
    for (int k = 2; k < FRAME_BYTES; k++) begin
      ff_short[k] = pay_b[k-2];
    end

    // escape form: zero 12-bit length, then the 32-bit length
    ff_long = {PCI_FF, 4'h0, 8'h00, s1_len_r, PAD_BYTE, PAD_BYTE};

    cf_bytes[0] = {PCI_CF, seq_r};
    for (int k = 1; k < FRAME_BYTES; k++) begin
      cf_bytes[k] = (3'(k - 1) < cf_n) ? pay_b[k-1] : PAD_BYTE;
    end

    fc_bytes = {PCI_FC, 2'b00, s1_fs_r, block_size_r, st_min_r,
                PAD_BYTE, PAD_BYTE, PAD_BYTE, PAD_BYTE, PAD_BYTE};
  end

  // Request checks, frame select and next session state
  always_comb begin
    built      = 1'b0;
    res_status = ST_OK;
    frame      = '0;
    busy_nxt   = busy_r;
    seq_nxt    = seq_r;
    left_nxt   = left_r;
    unique case (s1_mode_r)
      MODE_SINGLE: begin
        if (s1_len_r == '0 || s1_len_r > (addr_mode_r ? SF_MAX_EXT : SF_MAX_NORMAL)) begin
          res_status = ST_BAD_LEN;
        end else if (can_id == '0) begin
          res_status = ST_BAD_ID;
        end else begin
          built = 1'b1;
          frame = addr_mode_r ? sf_ext : sf_norm;
        end
      end
      MODE_FIRST: begin
        priority if (s1_len_r == '0) begin
          res_status = ST_BAD_LEN;
        end else if (busy_r) begin
          res_status = ST_BUSY;
        end else if (s1_len_r <= SF_MAX_NORMAL) begin
          res_status = ST_BAD_LEN;
        end else if (addr_mode_r) begin
          res_status = ST_UNSUPPORTED;
        end else if (can_id == '0) begin
          res_status = ST_BAD_ID;
        end else begin
          built    = 1'b1;
          busy_nxt = 1'b1;
          seq_nxt  = 4'd1;
          if (s1_len_r <= FF_SHORT_MAX) begin
            frame    = ff_short;
            left_nxt = s1_len_r - FF_CARRIED;
          end else begin
            frame    = ff_long;
            left_nxt = s1_len_r;
          end
        end
      end
      MODE_CONSECUTIVE: begin
        if (!busy_r) begin
          res_status = ST_IDLE;
        end else if (can_id == '0) begin
          res_status = ST_BAD_ID;
        end else begin
          built    = 1'b1;
          frame    = cf_bytes;
          left_nxt = cf_left;
          seq_nxt  = seq_r + 4'd1;
          busy_nxt = (cf_left != '0);
        end
      end
      MODE_FLOW_CTRL: begin
        if (s1_fs_r == FS_INVALID) begin
          res_status = ST_BAD_FS;
        end else if (can_id == '0) begin
          res_status = ST_BAD_ID;
        end else begin
          built = 1'b1;
          frame = fc_bytes;
        end
      end
      MODE_RELEASE: begin
        busy_nxt = 1'b0;
        seq_nxt  = '0;
        left_nxt = '0;
      end
      default: begin
        res_status = ST_UNSUPPORTED;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_mode_r     <= 1'b0;
      target_addr_r   <= '0;
      source_addr_r   <= '0;
      ta_functional_r <= 1'b0;
      functional_id_r <= '0;
      block_size_r    <= '0;
      st_min_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ADDR_MODE:     addr_mode_r     <= cfg_wdata[0];
        CFG_TARGET_ADDR:   target_addr_r   <= cfg_wdata[7:0];
        CFG_SOURCE_ADDR:   source_addr_r   <= cfg_wdata[7:0];
        CFG_TA_FUNCTIONAL: ta_functional_r <= cfg_wdata[0];
        CFG_FUNCTIONAL_ID: functional_id_r <= cfg_wdata;
        CFG_BLOCK_SIZE:    block_size_r    <= cfg_wdata[7:0];
        CFG_ST_MIN:        st_min_r        <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline control and session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      seq_r       <= '0;
      left_r      <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      // advance the session only when the request leaves the input stage
      if (s1_fire) begin
        busy_r <= busy_nxt;
        seq_r  <= seq_nxt;
        left_r <= left_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser;
      s1_len_r  <= in_tdata[31:0];
      s1_pay_r  <= in_tdata[87:32];
      s1_fs_r   <= in_tdata[89:88];
    end
    if (s1_fire) begin
      out_frame_r  <= built ? frame : '0;
      out_len_r    <= built ? FRAME_LEN_OK : 4'd0;
      out_id_r     <= can_id;
      out_status_r <= res_status;
    end
  end

`ifndef SYNTH
  // A session is open exactly while bytes remain to be sent.
  a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (left_r != '0))
    else $error("busy flag disagrees with remaining byte count");

  // A built frame always carries a good status.
  a_len_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_len_r != 4'd0 |-> out_status_r == ST_OK && out_len_r == FRAME_LEN_OK)
    else $error("frame length given without ok status");

  // An accepted first frame opens the session at sequence one.
  a_first_opens: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_mode_r == MODE_FIRST && res_status == ST_OK |=> busy_r && seq_r == 4'd1)
    else $error("first frame did not open the session");

  // A request leaving the input stage shows up as a result next cycle.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result lost between stages");

  // Input stalls only when the input stage holds an item that cannot move.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without cause");
`endif

endmodule

### tb/sv/tb_isotp_frame_segmenter.sv
// Self-checking testbench for the ISO-TP frame segmenter: directed and random requests.
module tb_isotp_frame_segmenter;
  import isotp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [7:0] PAD = 8'hCC;
  localparam logic [1:0] FS_CTS = 2'd0;
  localparam logic [1:0] FS_WAIT = 2'd1;
  localparam logic [1:0] FS_BAD = 2'd3;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  len;
    logic [10:0] id;
    logic [2:0]  status;
  } frame_t;

  class frame_scoreboard;
    logic        addr_mode, ta_func;
    logic [7:0]  target_addr, source_addr, block_size, st_min;
    logic [10:0] func_id;
    logic        busy;
    logic [3:0]  seq;
    logic [31:0] left;
    frame_t      frames_due[$];
    int          mismatches;

    function new();
      addr_mode = 0; ta_func = 0; target_addr = 0; source_addr = 0;
      block_size = 0; st_min = 0; func_id = 0;
      busy = 0; seq = 0; left = 0; mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [10:0] v);
      case (idx)
        CFG_ADDR_MODE:     addr_mode = v[0];
        CFG_TARGET_ADDR:   target_addr = v[7:0];
        CFG_SOURCE_ADDR:   source_addr = v[7:0];
        CFG_TA_FUNCTIONAL: ta_func = v[0];
        CFG_FUNCTIONAL_ID: func_id = v;
        CFG_BLOCK_SIZE:    block_size = v[7:0];
        CFG_ST_MIN:        st_min = v[7:0];
        default: ;
      endcase
    endfunction

    function logic [10:0] frame_id();
      if (ta_func) return func_id;
      if (!addr_mode) return {source_addr[4:0], target_addr[4:0], 1'b0};
      return {source_addr, 3'b000};
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function logic session_open();
      return busy;
    endfunction

    // Work out the frame that one accepted request yields and advance the session.
    function void note_request(logic [2:0] mode, logic [31:0] len, logic [55:0] pay,
                               logic [1:0] fs);
      frame_t      r;
      logic [7:0]  b [8];
      logic [31:0] n;
      logic        built;
      int          k, i;
      r.id = frame_id();
      r.status = ST_OK;
      built = 1'b0;
      for (i = 0; i < 8; i++) b[i] = PAD;
      case (mode)
        MODE_SINGLE: begin
          if (len == 0 || len > (addr_mode ? 32'd6 : 32'd7)) r.status = ST_BAD_LEN;
          else if (r.id == 0) r.status = ST_BAD_ID;
          else begin
            k = 0;
            if (addr_mode) begin
              b[0] = target_addr;
              k = 1;
            end
            b[k] = len[7:0];
            for (i = 0; i < int'(len); i++) b[k + 1 + i] = pay[55 - 8 * i -: 8];
            built = 1'b1;
          end
        end
        MODE_FIRST: begin
          if (len == 0) r.status = ST_BAD_LEN;
          else if (busy) r.status = ST_BUSY;
          else if (len <= 32'd7) r.status = ST_BAD_LEN;
          else if (addr_mode) r.status = ST_UNSUPPORTED;
          else if (r.id == 0) r.status = ST_BAD_ID;
          else begin
            if (len <= 32'd4095) begin
              b[0] = {PCI_FF, len[11:8]};
              b[1] = len[7:0];
              for (i = 0; i < 6; i++) b[2 + i] = pay[55 - 8 * i -: 8];
              left = len - 32'd6;
            end else begin
              // escape form: 32-bit length, no payload carried
              b[0] = {PCI_FF, 4'h0};
              b[1] = 8'h00;
              b[2] = len[31:24];
              b[3] = len[23:16];
              b[4] = len[15:8];
              b[5] = len[7:0];
              left = len;
            end
            busy = 1'b1;
            seq = 4'd1;
            built = 1'b1;
          end
        end
        MODE_CONSECUTIVE: begin
          if (!busy) r.status = ST_IDLE;
          else if (r.id == 0) r.status = ST_BAD_ID;
          else begin
            n = (left < 32'd7) ? left : 32'd7;
            b[0] = {PCI_CF, seq};
            for (i = 0; i < int'(n); i++) b[1 + i] = pay[55 - 8 * i -: 8];
            left = left - n;
            seq = seq + 4'd1;
            if (left == 0) busy = 1'b0;
            built = 1'b1;
          end
        end
        MODE_FLOW_CTRL: begin
          if (fs == FS_BAD) r.status = ST_BAD_FS;
          else if (r.id == 0) r.status = ST_BAD_ID;
          else begin
            b[0] = {PCI_FC, 2'b00, fs};
            b[1] = block_size;
            b[2] = st_min;
            built = 1'b1;
          end
        end
        MODE_RELEASE: begin
          busy = 1'b0;
          seq = 4'd0;
          left = 32'd0;
        end
        default: r.status = ST_UNSUPPORTED;
      endcase
      r.bytes = '0;
      if (built) for (i = 0; i < 8; i++) r.bytes[63 - 8 * i -: 8] = b[i];
      r.len = built ? 4'd8 : 4'd0;
      frames_due.push_back(r);
    endfunction

    function void check_frame(logic [OUT_TDATA_W-1:0] d);
      frame_t want;
      if (frames_due.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, got %h", $time, d);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      if (d[63:0] !== want.bytes) begin
        $display("%0t: frame_bytes expected %h, got %h", $time, want.bytes, d[63:0]);
        mismatches++;
      end
      if (d[67:64] !== want.len) begin
        $display("%0t: frame_len expected %0d, got %0d", $time, want.len, d[67:64]);
        mismatches++;
      end
      if (d[78:68] !== want.id) begin
        $display("%0t: can_id expected %h, got %h", $time, want.id, d[78:68]);
        mismatches++;
      end
      if (d[81:79] !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, d[81:79]);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic calm = 1'b0;
  logic hold_request = 1'b0;
  int   sent = 0;
  int   cycles = 0;
  frame_scoreboard sb = new();

  isotp_frame_segmenter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, or one long counted hold-off on request.
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request <= 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // Handshake signals are stable at the falling edge; a transfer follows at the next rise.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata);
  end

  function automatic logic [55:0] rand_pay();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[55:0];
  endfunction

  function automatic logic [1:0] rand_fs();
    return 2'($urandom_range(0, 3));
  endfunction

  // Called right after a rising edge; returns right after the edge of the transfer.
  task automatic send_request(logic [2:0] mode, logic [31:0] len, logic [55:0] pay,
                              logic [1:0] fs);
    int gap;
    if (!calm && $urandom_range(0, 99) < 5) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - 90){1'b0}}, fs, pay, len};
    in_tuser <= mode;
    do @(negedge clk); while (!in_tready);
    sb.note_request(mode, len, pay, fs);
    @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic am, logic [7:0] ta, logic [7:0] sa, logic tf,
                               logic [10:0] fid, logic [7:0] bs, logic [7:0] stm);
    drain();
    write_reg(CFG_ADDR_MODE, {10'd0, am});
    write_reg(CFG_TARGET_ADDR, {3'd0, ta});
    write_reg(CFG_SOURCE_ADDR, {3'd0, sa});
    write_reg(CFG_TA_FUNCTIONAL, {10'd0, tf});
    write_reg(CFG_FUNCTIONAL_ID, fid);
    write_reg(CFG_BLOCK_SIZE, {3'd0, bs});
    write_reg(CFG_ST_MIN, {3'd0, stm});
    cfg_we <= 1'b0;
  endtask

  // One transmit session: first frame, consecutive frames with stray traffic mixed in.
  task automatic run_session();
    int          r, cap, cfs;
    logic [31:0] len;
    r = $urandom_range(0, 99);
    if (r < 75) len = $urandom_range(8, 160);
    else if (r < 85) len = $urandom_range(4000, 4095);
    else if (r < 95) len = $urandom_range(4096, 1 << 20);
    else len = $urandom();
    cap = ($urandom_range(0, 99) < 90) ? 40 : $urandom_range(0, 4);
    send_request(MODE_FIRST, len, rand_pay(), rand_fs());
    cfs = 0;
    while (sb.session_open() && cfs < cap) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_request(MODE_FLOW_CTRL, $urandom(), rand_pay(), rand_fs());
      else if (r < 12) send_request(MODE_SINGLE, $urandom_range(0, 8), rand_pay(), rand_fs());
      else if (r < 14) send_request(MODE_FIRST, $urandom(), rand_pay(), rand_fs());
      send_request(MODE_CONSECUTIVE, $urandom(), rand_pay(), rand_fs());
      cfs++;
    end
    if (sb.session_open() && $urandom_range(0, 99) < 85)
      send_request(MODE_RELEASE, $urandom(), rand_pay(), rand_fs());
  endtask

  task automatic random_phase(int count);
    int          stop, r;
    logic [31:0] len;
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom();
      if (r < 55) run_session();
      else if (r < 70) send_request(MODE_SINGLE, len, rand_pay(), rand_fs());
      else if (r < 80) send_request(MODE_FLOW_CTRL, $urandom(), rand_pay(), rand_fs());
      else if (r < 85) send_request(MODE_RELEASE, $urandom(), rand_pay(), rand_fs());
      else if (r < 91) send_request(MODE_CONSECUTIVE, $urandom(), rand_pay(), rand_fs());
      else if (r < 94) send_request(MODE_FIRST, len, rand_pay(), rand_fs());
      else if (r < 98)
        send_request(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), $urandom(),
                     rand_pay(), rand_fs());
      else drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: identifier is zero, so every frame build is refused.
    send_request(MODE_SINGLE, 32'd3, rand_pay(), FS_CTS);
    send_request(MODE_FLOW_CTRL, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_FIRST, 32'd100, rand_pay(), FS_CTS);
    send_request(MODE_CONSECUTIVE, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_RELEASE, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_UNUSED_HI, 32'hFFFF_FFFF, rand_pay(), FS_BAD);

    apply_setting(1'b0, 8'hFF, 8'hFF, 1'b0, 11'h7FF, 8'hFF, 8'hFF);
    send_request(MODE_SINGLE, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_SINGLE, 32'd8, rand_pay(), FS_CTS);
    send_request(MODE_SINGLE, 32'd7, {56{1'b1}}, FS_BAD);
    send_request(MODE_SINGLE, 32'd1, 56'd0, FS_CTS);
    send_request(MODE_FIRST, 32'd7, rand_pay(), FS_CTS);
    send_request(MODE_FIRST, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_FIRST, 32'd4095, 56'h11223344556677, FS_CTS);
    // second first frame while the session is open
    send_request(MODE_FIRST, 32'd20, rand_pay(), FS_CTS);
    send_request(MODE_CONSECUTIVE, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_RELEASE, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_FIRST, 32'hFFFF_FFFF, rand_pay(), FS_CTS);
    send_request(MODE_CONSECUTIVE, 32'd0, {56{1'b1}}, FS_CTS);
    send_request(MODE_RELEASE, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_FLOW_CTRL, 32'd0, rand_pay(), FS_BAD);
    send_request(MODE_FLOW_CTRL, 32'd0, rand_pay(), FS_WAIT);
    send_request(MODE_FLOW_CTRL, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_UNUSED_LO, 32'd0, rand_pay(), FS_CTS);
    send_request(MODE_UNUSED_MID, 32'd0, rand_pay(), FS_CTS);

    apply_setting(1'b0, 8'($urandom()), 8'($urandom()), 1'b0, 11'($urandom()),
                  8'($urandom()), 8'($urandom()));
    hold_request <= 1'b1;
    random_phase(400);

    // extended addressing
    apply_setting(1'b1, 8'h00, 8'hFF, 1'b0, 11'h000, 8'h00, 8'h00);
    random_phase(250);

    apply_setting(1'b0, 8'h12, 8'h34, 1'b1, 11'h001, 8'h00, 8'hFF);
    random_phase(300);

    apply_setting(1'b1, 8'hFF, 8'h00, 1'b1, 11'h7FF, 8'hFF, 8'h00);
    random_phase(200);

    // normal addressing with a zero identifier
    apply_setting(1'b0, 8'h20, 8'h20, 1'b0, 11'h7FF, 8'h5A, 8'hA5);
    random_phase(40);

    apply_setting(1'b0, 8'($urandom()), 8'($urandom()), 1'b0, 11'($urandom()),
                  8'($urandom()), 8'($urandom()));
    calm <= 1'b1;
    random_phase(230);
    calm <= 1'b0;
    random_phase(230);

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
